// ===== rtl/lfsc_pkg.sv =====
// lfsc_pkg: shared types and constants for the line follower search controller
// no dependencies; used by the motor channel interface and the core

package lfsc_pkg;

  localparam int unsigned SPEED_W = 7;
  localparam int unsigned TICK_W  = 10;
  localparam int unsigned LOST_W  = 11;
  localparam int unsigned CROSS_W = 16;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
  localparam logic [LOST_W-1:0] LOST_SAT = 11'd2047;

  // floor(x/3) = (x*171) >> 9 for all x below 512
  localparam logic [14:0] SLOW_MUL   = 15'd171;
  localparam int unsigned SLOW_SHIFT = 9;

  localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST = 7'd60;
  localparam logic [TICK_W-1:0]  MAX_LOST_RST    = 10'd150;
  localparam logic [TICK_W-1:0]  INIT_TURN_RST   = 10'd100;
  localparam logic [TICK_W-1:0]  ALT_TURN_RST    = 10'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_SPEED = 2'd0,
    REG_MAX_LOST    = 2'd1,
    REG_INIT_TURN   = 2'd2,
    REG_ALT_TURN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_t;

  // cw: left forward, right reverse; ccw is the mirror
  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_CW   = 2'd1,
    SIDE_CCW  = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    STG_INIT  = 2'd0,
    STG_FIRST = 2'd1,
    STG_ALT   = 2'd2
  } stage_t;

  typedef struct packed {
    logic [1:0]        left_drive;
    logic [DUTY_W-1:0] left_duty;
    logic [1:0]        right_drive;
    logic [DUTY_W-1:0] right_duty;
  } motor_cmd_t;

endpackage

// ===== rtl/lfsc_sensor_if.sv =====
// lfsc_sensor_if: valid/ready channel carrying one three-bit sensor sample
// depends on nothing

interface lfsc_sensor_if;
  logic valid;
  logic ready;
  logic left_sensor;
  logic middle_sensor;
  logic right_sensor;

  modport source (output valid, left_sensor, middle_sensor, right_sensor, input ready);
  modport sink   (input valid, left_sensor, middle_sensor, right_sensor, output ready);
endinterface

// ===== rtl/lfsc_motor_if.sv =====
// lfsc_motor_if: valid/ready channel carrying one motor command result
// depends on lfsc_pkg for field widths

interface lfsc_motor_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  left_drive;
  logic [lfsc_pkg::DUTY_W-1:0] left_duty;
  logic [1:0]                  right_drive;
  logic [lfsc_pkg::DUTY_W-1:0] right_duty;
  logic                        crossroad_hold;
  logic [lfsc_pkg::CROSS_W-1:0] crossings_seen;

  modport source (output valid, left_drive, left_duty, right_drive, right_duty,
                  crossroad_hold, crossings_seen, input ready);
  modport sink   (input valid, left_drive, left_duty, right_drive, right_duty,
                  crossroad_hold, crossings_seen, output ready);
endinterface

// ===== rtl/line_follower_search_controller_core.sv =====
// Line follower search controller: one sensor sample in, one motor command out.
// Samples pass through an input register and a result register with the
// decision logic between them, so one sample is taken every clock unless the
// result register is stalled; a stalled result register holds the whole
// pipeline. Search state and the crossing counter update as a sample moves into
// the result register. Configuration writes are taken at any cycle and apply
// to samples not yet in the result register. No clearing pass after reset.
// depends on lfsc_pkg, lfsc_sensor_if, lfsc_motor_if

module line_follower_search_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lfsc_sensor_if.sink                     in_ch,
  lfsc_motor_if.source                    out_ch
);

  logic [lfsc_pkg::SPEED_W-1:0] drive_speed_r;
  logic [lfsc_pkg::TICK_W-1:0]  max_lost_r;
  logic [lfsc_pkg::TICK_W-1:0]  init_turn_r;
  logic [lfsc_pkg::TICK_W-1:0]  alt_turn_r;

  logic s1_valid_r;
  logic s1_left_r, s1_mid_r, s1_right_r;
  logic out_valid_r;

  lfsc_pkg::motor_cmd_t        cmd_r, cmd_nxt;
  logic                        hold_r, hold_nxt;

  lfsc_pkg::side_t             last_side_r, last_side_nxt;
  lfsc_pkg::side_t             search_side_r, search_side_nxt;
  lfsc_pkg::stage_t            stage_r, stage_nxt;
  logic [lfsc_pkg::CROSS_W-1:0] cross_cnt_r, cross_cnt_nxt;
  logic [lfsc_pkg::LOST_W-1:0]  lost_r, lost_nxt;
  logic [lfsc_pkg::TICK_W-1:0]  stage_ticks_r, stage_ticks_nxt;

  logic                          advance, in_fire, s1_fire;
  logic [lfsc_pkg::DUTY_W-1:0]   full_duty, slow_duty;
  logic [14:0]                   slow_prod;
  logic [lfsc_pkg::TICK_W-1:0]   ticks_inc;
  lfsc_pkg::side_t               side_sel;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_fire      = s1_valid_r && advance;

  function automatic lfsc_pkg::motor_cmd_t spin(lfsc_pkg::side_t side,
                                                logic [lfsc_pkg::DUTY_W-1:0] duty);
    lfsc_pkg::motor_cmd_t c;
    c.left_duty  = duty;
    c.right_duty = duty;
    if (side == lfsc_pkg::SIDE_CW) begin
      c.left_drive  = lfsc_pkg::DRV_FWD;
      c.right_drive = lfsc_pkg::DRV_REV;
    end else begin
      c.left_drive  = lfsc_pkg::DRV_REV;
      c.right_drive = lfsc_pkg::DRV_FWD;
    end
    return c;
  endfunction

  assign full_duty = (drive_speed_r > lfsc_pkg::DUTY_MAX) ? lfsc_pkg::DUTY_MAX : drive_speed_r;
  assign slow_prod = 15'(drive_speed_r) * lfsc_pkg::SLOW_MUL;
  assign slow_duty = lfsc_pkg::DUTY_W'(slow_prod >> lfsc_pkg::SLOW_SHIFT);
  assign ticks_inc = stage_ticks_r + 1'b1;

  always_comb begin
    cmd_nxt         = '{lfsc_pkg::DRV_OFF, '0, lfsc_pkg::DRV_OFF, '0};
    hold_nxt        = 1'b0;
    last_side_nxt   = last_side_r;
    search_side_nxt = search_side_r;
    stage_nxt       = stage_r;
    cross_cnt_nxt   = cross_cnt_r;
    lost_nxt        = lost_r;
    stage_ticks_nxt = stage_ticks_r;
    side_sel        = lfsc_pkg::SIDE_CW;

    if (s1_left_r || s1_mid_r || s1_right_r) begin
      // line seen
      lost_nxt        = '0;
      stage_nxt       = lfsc_pkg::STG_INIT;
      search_side_nxt = lfsc_pkg::SIDE_CW;
      if (s1_mid_r && !s1_left_r && !s1_right_r) begin
        cmd_nxt       = '{lfsc_pkg::DRV_FWD, full_duty, lfsc_pkg::DRV_FWD, full_duty};
        last_side_nxt = lfsc_pkg::SIDE_NONE;
      end else if (s1_left_r && !s1_mid_r) begin
        cmd_nxt       = spin(lfsc_pkg::SIDE_CW, full_duty);
        last_side_nxt = lfsc_pkg::SIDE_CW;
      end else if (s1_right_r && !s1_mid_r) begin
        cmd_nxt       = spin(lfsc_pkg::SIDE_CCW, full_duty);
        last_side_nxt = lfsc_pkg::SIDE_CCW;
      end else if (!s1_right_r) begin
        cmd_nxt       = '{lfsc_pkg::DRV_FWD, full_duty, lfsc_pkg::DRV_FWD, slow_duty};
        last_side_nxt = lfsc_pkg::SIDE_CW;
      end else if (!s1_left_r) begin
        cmd_nxt       = '{lfsc_pkg::DRV_FWD, slow_duty, lfsc_pkg::DRV_FWD, full_duty};
        last_side_nxt = lfsc_pkg::SIDE_CCW;
      end else begin
        // crossroad
        cross_cnt_nxt = cross_cnt_r + 1'b1;
        if (cross_cnt_nxt[0]) begin
          cmd_nxt  = spin(lfsc_pkg::SIDE_CW, full_duty);
          hold_nxt = 1'b1;
        end else begin
          cmd_nxt  = '{lfsc_pkg::DRV_FWD, full_duty, lfsc_pkg::DRV_FWD, full_duty};
        end
      end
    end else begin
      // line lost: search
      lost_nxt = (lost_r < lfsc_pkg::LOST_SAT) ? lost_r + 1'b1 : lost_r;
      if (lost_nxt > {1'b0, max_lost_r}) begin
        cmd_nxt = '{lfsc_pkg::DRV_OFF, '0, lfsc_pkg::DRV_OFF, '0};
      end else begin
        case (stage_r)
          lfsc_pkg::STG_INIT: begin
            side_sel        = (last_side_r == lfsc_pkg::SIDE_CCW) ?
                              lfsc_pkg::SIDE_CCW : lfsc_pkg::SIDE_CW;
            search_side_nxt = side_sel;
            cmd_nxt         = spin(side_sel, full_duty);
            stage_nxt       = lfsc_pkg::STG_FIRST;
            stage_ticks_nxt = '0;
          end
          lfsc_pkg::STG_FIRST: begin
            cmd_nxt         = spin(search_side_r, full_duty);
            stage_ticks_nxt = ticks_inc;
            if (ticks_inc >= init_turn_r) begin
              stage_nxt       = lfsc_pkg::STG_ALT;
              stage_ticks_nxt = '0;
            end
          end
          default: begin
            cmd_nxt         = spin(search_side_r, full_duty);
            stage_ticks_nxt = ticks_inc;
            if (ticks_inc >= alt_turn_r) begin
              search_side_nxt = (search_side_r == lfsc_pkg::SIDE_CW) ?
                                lfsc_pkg::SIDE_CCW : lfsc_pkg::SIDE_CW;
              stage_ticks_nxt = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r <= lfsc_pkg::DRIVE_SPEED_RST;
      max_lost_r    <= lfsc_pkg::MAX_LOST_RST;
      init_turn_r   <= lfsc_pkg::INIT_TURN_RST;
      alt_turn_r    <= lfsc_pkg::ALT_TURN_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_side_r   <= lfsc_pkg::SIDE_NONE;
      search_side_r <= lfsc_pkg::SIDE_CW;
      stage_r       <= lfsc_pkg::STG_INIT;
      cross_cnt_r   <= '0;
      lost_r        <= '0;
      stage_ticks_r <= '0;
    end else begin
      if (cfg_we) begin
        case (lfsc_pkg::cfg_reg_t'(cfg_index))
          lfsc_pkg::REG_DRIVE_SPEED: drive_speed_r <= cfg_wdata[lfsc_pkg::SPEED_W-1:0];
          lfsc_pkg::REG_MAX_LOST:    max_lost_r    <= cfg_wdata;
          lfsc_pkg::REG_INIT_TURN:   init_turn_r   <= cfg_wdata;
          lfsc_pkg::REG_ALT_TURN:    alt_turn_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        last_side_r   <= last_side_nxt;
        search_side_r <= search_side_nxt;
        stage_r       <= stage_nxt;
        cross_cnt_r   <= cross_cnt_nxt;
        lost_r        <= lost_nxt;
        stage_ticks_r <= stage_ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_left_r  <= in_ch.left_sensor;
      s1_mid_r   <= in_ch.middle_sensor;
      s1_right_r <= in_ch.right_sensor;
    end
    if (s1_fire) begin
      cmd_r  <= cmd_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_drive     = cmd_r.left_drive;
  assign out_ch.left_duty      = cmd_r.left_duty;
  assign out_ch.right_drive    = cmd_r.right_drive;
  assign out_ch.right_duty     = cmd_r.right_duty;
  assign out_ch.crossroad_hold = hold_r;
  assign out_ch.crossings_seen = cross_cnt_r;

  // hold only comes with a clockwise spin
  a_hold_spin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hold_r |-> cmd_r.left_drive == lfsc_pkg::DRV_FWD &&
                              cmd_r.right_drive == lfsc_pkg::DRV_REV)
    else $error("crossroad hold without clockwise spin");

  // stop means both motors off at zero duty
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cmd_r.left_drive == lfsc_pkg::DRV_OFF |->
      cmd_r.right_drive == lfsc_pkg::DRV_OFF && cmd_r.left_duty == '0 &&
      cmd_r.right_duty == '0)
    else $error("partial stop command");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cmd_r.left_duty <= lfsc_pkg::DUTY_MAX &&
                    cmd_r.right_duty <= lfsc_pkg::DUTY_MAX)
    else $error("duty above limit");

  // a crossroad bumps the counter by exactly one
  a_cross_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_left_r && s1_mid_r && s1_right_r |=>
      cross_cnt_r == $past(cross_cnt_r) + 1'b1)
    else $error("crossing count step");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/line_follower_search_controller_core_tb.sv =====
`timescale 1ns / 100ps
// line_follower_search_controller_core_tb: self-checking bench with a scoreboard class
// that predicts each motor command from the sensor transfers and checks the results
// depends on lfsc_pkg, lfsc_sensor_if, lfsc_motor_if and line_follower_search_controller_core

module line_follower_search_controller_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned REPORT_LINES = 40;
  localparam int unsigned RANDOM_ITEMS = 540;

  typedef logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    lfsc_pkg::drive_t              left_drive;
    logic [lfsc_pkg::DUTY_W-1:0]   left_duty;
    lfsc_pkg::drive_t              right_drive;
    logic [lfsc_pkg::DUTY_W-1:0]   right_duty;
    logic                          hold;
    logic [lfsc_pkg::CROSS_W-1:0]  crossings;
  } motor_result_t;

  class motor_scoreboard;
    logic [lfsc_pkg::SPEED_W-1:0] drive_speed;
    logic [lfsc_pkg::TICK_W-1:0]  max_lost;
    logic [lfsc_pkg::TICK_W-1:0]  init_turn;
    logic [lfsc_pkg::TICK_W-1:0]  alt_turn;
    lfsc_pkg::side_t              last_side;
    logic [lfsc_pkg::CROSS_W-1:0] crossings;
    logic [lfsc_pkg::LOST_W-1:0]  lost;
    lfsc_pkg::side_t              search_side;
    lfsc_pkg::stage_t             stage;
    logic [lfsc_pkg::TICK_W-1:0]  stage_ticks;
    motor_result_t                expected_q[$];
    int unsigned                  errors;
    int unsigned                  checked;

    function new();
      drive_speed = lfsc_pkg::DRIVE_SPEED_RST;
      max_lost    = lfsc_pkg::MAX_LOST_RST;
      init_turn   = lfsc_pkg::INIT_TURN_RST;
      alt_turn    = lfsc_pkg::ALT_TURN_RST;
      last_side   = lfsc_pkg::SIDE_NONE;
      crossings   = '0;
      lost        = '0;
      search_side = lfsc_pkg::SIDE_CW;
      stage       = lfsc_pkg::STG_INIT;
      stage_ticks = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(lfsc_pkg::cfg_reg_t idx, cfg_data_t v);
      case (idx)
        lfsc_pkg::REG_DRIVE_SPEED: drive_speed = v[lfsc_pkg::SPEED_W-1:0];
        lfsc_pkg::REG_MAX_LOST:    max_lost = v;
        lfsc_pkg::REG_INIT_TURN:   init_turn = v;
        default:                   alt_turn = v;
      endcase
    endfunction

    function logic [lfsc_pkg::DUTY_W-1:0] full_duty();
      return (drive_speed > lfsc_pkg::DUTY_MAX) ? lfsc_pkg::DUTY_MAX : drive_speed;
    endfunction

    function motor_result_t motors(lfsc_pkg::drive_t ld, logic [lfsc_pkg::DUTY_W-1:0] lp,
                                   lfsc_pkg::drive_t rd, logic [lfsc_pkg::DUTY_W-1:0] rp);
      motor_result_t res;
      res.left_drive  = ld;
      res.left_duty   = lp;
      res.right_drive = rd;
      res.right_duty  = rp;
      res.hold        = 1'b0;
      res.crossings   = '0;
      return res;
    endfunction

    function motor_result_t spin(lfsc_pkg::side_t s);
      if (s == lfsc_pkg::SIDE_CW)
        return motors(lfsc_pkg::DRV_FWD, full_duty(), lfsc_pkg::DRV_REV, full_duty());
      return motors(lfsc_pkg::DRV_REV, full_duty(), lfsc_pkg::DRV_FWD, full_duty());
    endfunction

    function void line_seen();
      lost        = '0;
      stage       = lfsc_pkg::STG_INIT;
      search_side = lfsc_pkg::SIDE_CW;
    endfunction

    function void note_sample(logic l, logic m, logic r);
      motor_result_t               res;
      logic [lfsc_pkg::DUTY_W-1:0] slow;
      slow = drive_speed / 7'd3;
      if (m && !l && !r) begin
        res = motors(lfsc_pkg::DRV_FWD, full_duty(), lfsc_pkg::DRV_FWD, full_duty());
        last_side = lfsc_pkg::SIDE_NONE;
        line_seen();
      end else if (l && !m) begin
        res = spin(lfsc_pkg::SIDE_CW);
        last_side = lfsc_pkg::SIDE_CW;
        line_seen();
      end else if (r && !m) begin
        res = spin(lfsc_pkg::SIDE_CCW);
        last_side = lfsc_pkg::SIDE_CCW;
        line_seen();
      end else if (m && l && !r) begin
        res = motors(lfsc_pkg::DRV_FWD, full_duty(), lfsc_pkg::DRV_FWD, slow);
        last_side = lfsc_pkg::SIDE_CW;
        line_seen();
      end else if (m && r && !l) begin
        res = motors(lfsc_pkg::DRV_FWD, slow, lfsc_pkg::DRV_FWD, full_duty());
        last_side = lfsc_pkg::SIDE_CCW;
        line_seen();
      end else if (l && r) begin
        crossings = crossings + 1'b1;
        if (crossings[0]) begin
          res = spin(lfsc_pkg::SIDE_CW);
          res.hold = 1'b1;
        end else begin
          res = motors(lfsc_pkg::DRV_FWD, full_duty(), lfsc_pkg::DRV_FWD, full_duty());
        end
        line_seen();
      end else begin
        if (lost != lfsc_pkg::LOST_SAT) lost = lost + 1'b1;
        if (lost > {1'b0, max_lost}) begin
          res = motors(lfsc_pkg::DRV_OFF, '0, lfsc_pkg::DRV_OFF, '0);
        end else if (stage == lfsc_pkg::STG_INIT) begin
          search_side = (last_side == lfsc_pkg::SIDE_CCW) ?
                        lfsc_pkg::SIDE_CCW : lfsc_pkg::SIDE_CW;
          res = spin(search_side);
          stage = lfsc_pkg::STG_FIRST;
          stage_ticks = '0;
        end else if (stage == lfsc_pkg::STG_FIRST) begin
          stage_ticks = stage_ticks + 1'b1;
          res = spin(search_side);
          if (stage_ticks >= init_turn) begin
            stage = lfsc_pkg::STG_ALT;
            stage_ticks = '0;
          end
        end else begin
          stage_ticks = stage_ticks + 1'b1;
          res = spin(search_side);
          if (stage_ticks >= alt_turn) begin
            search_side = (search_side == lfsc_pkg::SIDE_CW) ?
                          lfsc_pkg::SIDE_CCW : lfsc_pkg::SIDE_CW;
            stage_ticks = '0;
          end
        end
      end
      res.crossings = crossings;
      expected_q.push_back(res);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= REPORT_LINES)
        $display("ERROR command %0d %s: got %0d expected %0d", checked, what, got, want);
    endtask

    task check_result(motor_result_t got);
      motor_result_t want;
      if (expected_q.size() == 0) begin
        report("transfer with no command pending", got.crossings, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.left_drive !== want.left_drive)
        report("left_drive", got.left_drive, want.left_drive);
      if (got.left_duty !== want.left_duty)
        report("left_duty", got.left_duty, want.left_duty);
      if (got.right_drive !== want.right_drive)
        report("right_drive", got.right_drive, want.right_drive);
      if (got.right_duty !== want.right_duty)
        report("right_duty", got.right_duty, want.right_duty);
      if (got.hold !== want.hold)
        report("crossroad_hold", got.hold, want.hold);
      if (got.crossings !== want.crossings)
        report("crossings_seen", got.crossings, want.crossings);
      checked++;
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  cfg_data_t                       cfg_wdata;
  bit                              steady;
  int unsigned                     stall_left;
  int unsigned                     samples_sent;
  int unsigned                     phases;
  motor_scoreboard                 sb;

  lfsc_sensor_if in_if();
  lfsc_motor_if  out_if();

  line_follower_search_controller_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return idle_span();
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    logic next_ready;
    if (steady) begin
      next_ready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      next_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 25) begin
      next_ready = 1'b0;
      stall_left = idle_span() - 1;
    end else begin
      next_ready = 1'b1;
    end
    out_if.ready <= next_ready;
  end

  always @(posedge clk) begin
    motor_result_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.left_drive  = lfsc_pkg::drive_t'(out_if.left_drive);
      seen.left_duty   = out_if.left_duty;
      seen.right_drive = lfsc_pkg::drive_t'(out_if.right_drive);
      seen.right_duty  = out_if.right_duty;
      seen.hold        = out_if.crossroad_hold;
      seen.crossings   = out_if.crossings_seen;
      sb.check_result(seen);
    end
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_sample(in_if.left_sensor, in_if.middle_sensor, in_if.right_sensor);
  end

  // lmr: left, middle, right
  task automatic send_sample(logic [2:0] lmr);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.left_sensor   <= lmr[2];
    in_if.middle_sensor <= lmr[1];
    in_if.right_sensor  <= lmr[0];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_lost(int unsigned n);
    repeat (n) send_sample(3'b000);
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(lfsc_pkg::cfg_reg_t idx, cfg_data_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(cfg_data_t speed, cfg_data_t max_lost,
                           cfg_data_t init_turn, cfg_data_t alt_turn);
    write_reg(lfsc_pkg::REG_DRIVE_SPEED, speed);
    write_reg(lfsc_pkg::REG_MAX_LOST, max_lost);
    write_reg(lfsc_pkg::REG_INIT_TURN, init_turn);
    write_reg(lfsc_pkg::REG_ALT_TURN, alt_turn);
    phases++;
  endtask

  function automatic cfg_data_t pick_ticks(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return 10'd1023;
    if (r < 25) return 10'd1;
    return cfg_data_t'($urandom_range(1, top));
  endfunction

  function automatic cfg_data_t pick_speed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return 10'd100;
    if (r < 45) return 10'd127;
    return cfg_data_t'($urandom_range(0, 127));
  endfunction

  initial begin
    int unsigned target;
    in_if.valid         = 1'b0;
    in_if.left_sensor   = 1'b0;
    in_if.middle_sensor = 1'b0;
    in_if.right_sensor  = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    steady              = 1'b0;
    samples_sent        = 0;
    phases              = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every pattern at reset settings
    send_sample(3'b010);
    send_sample(3'b100);
    send_sample(3'b101);
    send_sample(3'b001);
    send_sample(3'b110);
    send_sample(3'b011);
    send_sample(3'b111);
    send_sample(3'b111);
    send_lost(2);
    settle();

    // speed above full duty, zero turn lengths
    write_all(10'd127, 10'd1023, 10'd0, 10'd0);
    send_sample(3'b100);
    send_lost(4);
    send_sample(3'b110);
    settle();

    // stopped at once, zero speed
    write_all(10'd0, 10'd0, 10'd1023, 10'd1);
    send_lost(2);
    send_sample(3'b010);
    send_sample(3'b111);
    settle();

    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      write_all(pick_speed(), pick_ticks(60), pick_ticks(20), pick_ticks(8));
      steady = ($urandom_range(0, 3) == 0);
      repeat (12) begin
        if ($urandom_range(0, 99) < 65) begin
          send_sample(3'($urandom_range(1, 7)));
          if ($urandom_range(0, 9) == 0) send_lost($urandom_range(20, 80));
          else send_lost($urandom_range(1, 12));
        end else begin
          send_sample(3'($urandom_range(0, 7)));
        end
      end
      settle();
    end

    $display("%0d sensor samples sent, %0d motor commands checked, %0d register settings",
             samples_sent, sb.checked, phases);
    $display("covered all patterns, search stages, stop, zero turn lengths, speed saturation");
    if (sb.expected_q.size() != 0) sb.report("commands never seen", sb.expected_q.size(), 0);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
